/* hw/rtl/sssd_pkg.sv */
// Shared types, opcodes and glyph helpers for the seven-segment scan driver.
// No dependencies; imported by every module of the block.
package sssd_pkg;

	localparam int unsigned NumDigits = 8;
	localparam int unsigned PosW      = $clog2(NumDigits);
	localparam int unsigned CountW    = 32;

	localparam logic [1:0] OP_TIME   = 2'd0;
	localparam logic [1:0] OP_REMOTE = 2'd1;
	localparam logic [1:0] OP_SCAN   = 2'd2;

	localparam logic [7:0] SEG_OFF    = 8'h00;
	localparam logic [7:0] SEG_DP     = 8'h80;
	localparam logic [7:0] HOUR_MAX   = 8'd23;
	localparam logic [7:0] MINUTE_MAX = 8'd59;
	localparam logic [7:0] DIGIT_MAX  = 8'd9;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] hour;
		logic [7:0] minute;
		logic [7:0] remote_value;
	} req_t;

	typedef struct packed {
		logic [PosW-1:0]   digit_select;
		logic [7:0]        segments;
		logic              last;
		logic [CountW-1:0] scan_total;
	} rsp_t;

	// push of one scan's result pair into the result queue
	typedef struct packed {
		logic push;
		rsp_t first;
		rsp_t second;
	} q_push_t;

	typedef struct packed {
		logic space;
	} q_status_t;

	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		case (d)
			4'd0: g = 8'h3F;
			4'd1: g = 8'h06;
			4'd2: g = 8'h5B;
			4'd3: g = 8'h4F;
			4'd4: g = 8'h66;
			4'd5: g = 8'h6D;
			4'd6: g = 8'h7D;
			4'd7: g = 8'h07;
			4'd8: g = 8'h7F;
			4'd9: g = 8'h6F;
			default: g = SEG_OFF;
		endcase
		return g;
	endfunction

	// tens digit of a value below 60
	function automatic logic [3:0] tens(input logic [7:0] v);
		logic [3:0] t;
		if (v >= 8'd50)      t = 4'd5;
		else if (v >= 8'd40) t = 4'd4;
		else if (v >= 8'd30) t = 4'd3;
		else if (v >= 8'd20) t = 4'd2;
		else if (v >= 8'd10) t = 4'd1;
		else                 t = 4'd0;
		return t;
	endfunction

	function automatic logic [3:0] units(input logic [7:0] v);
		logic [7:0] t10;
		t10 = {4'd0, tens(v)} * 8'd10;
		return 4'(v - t10);
	endfunction

endpackage

/* hw/rtl/sssd_result_queue.sv */
// Two-entry result queue: holds the blank/digit pair of one scan tick.
// Depends on sssd_pkg.
module sssd_result_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  sssd_pkg::q_push_t   push,
	output sssd_pkg::q_status_t status,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output sssd_pkg::rsp_t      rsp
);
	import sssd_pkg::*;

	rsp_t       head_q;
	rsp_t       tail_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign rsp_valid    = (cnt_q != 2'd0);
	assign rsp          = head_q;
	assign pop          = rsp_valid && rsp_ready;
	// a pair fits only when the queue is empty after this cycle's pop
	assign status.space = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push.push) begin
			cnt_q <= 2'd2;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) begin
			head_q <= push.first;
			tail_q <= push.second;
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

endmodule

/* hw/rtl/sssd_core.sv */
// Display state, buffer rebuild and scan sequencing for one request.
// Depends on sssd_pkg.
module sssd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  sssd_pkg::req_t      req_s1,
	input  sssd_pkg::q_status_t status,
	output logic                take,
	output sssd_pkg::q_push_t   push
);
	import sssd_pkg::*;

	logic [7:0]        buf_q [NumDigits];
	logic [PosW-1:0]   pos_q;
	logic [PosW-1:0]   sel_q;
	logic              en_q;
	logic [7:0]        hour_q;
	logic [7:0]        min_q;
	logic [3:0]        rdig_q;
	logic              rval_q;
	logic [CountW-1:0] cnt_q;

	logic       is_time, is_remote, is_scan;
	logic       digit_ok, in_range, rebuild;
	logic [7:0] h, m;
	logic [3:0] dig;
	logic       dig_valid;

	assign is_time   = (req_s1.opcode == OP_TIME);
	assign is_remote = (req_s1.opcode == OP_REMOTE);
	assign is_scan   = (req_s1.opcode == OP_SCAN);
	assign digit_ok  = (req_s1.remote_value <= DIGIT_MAX);

	// a scan only waits when it will actually emit results
	assign take = valid_s1 && !(is_scan && en_q && !status.space);

	assign h         = is_time ? req_s1.hour : hour_q;
	assign m         = is_time ? req_s1.minute : min_q;
	assign dig       = is_remote ? req_s1.remote_value[3:0] : rdig_q;
	assign dig_valid = is_remote || rval_q;
	assign in_range  = (h <= HOUR_MAX) && (m <= MINUTE_MAX);
	assign rebuild   = take && (is_time || (is_remote && digit_ok)) && in_range;

	always_comb begin
		push.push                = take && is_scan && en_q;
		push.first.digit_select  = sel_q;
		push.first.segments      = SEG_OFF;
		push.first.last          = 1'b0;
		push.first.scan_total    = cnt_q;
		push.second.digit_select = pos_q;
		push.second.segments     = buf_q[pos_q];
		push.second.last         = 1'b1;
		push.second.scan_total   = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			sel_q  <= '0;
			en_q   <= 1'b0;
			hour_q <= '0;
			min_q  <= '0;
			rdig_q <= '0;
			rval_q <= 1'b0;
			cnt_q  <= '0;
		end else if (take) begin
			if (is_time) begin
				hour_q <= req_s1.hour;
				min_q  <= req_s1.minute;
				en_q   <= 1'b1;
			end
			if (is_remote && digit_ok) begin
				rdig_q <= req_s1.remote_value[3:0];
				rval_q <= 1'b1;
			end
			if (is_scan && en_q) begin
				sel_q <= pos_q;
				pos_q <= pos_q + 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumDigits; i++) begin
				buf_q[i] <= SEG_OFF;
			end
		end else if (rebuild) begin
			buf_q[0] <= SEG_OFF;
			buf_q[1] <= SEG_OFF;
			buf_q[2] <= SEG_OFF;
			buf_q[3] <= dig_valid ? glyph(dig) : SEG_OFF;
			buf_q[4] <= glyph(tens(h));
			buf_q[5] <= glyph(units(h)) | SEG_DP;
			buf_q[6] <= glyph(tens(m)) | SEG_DP;
			buf_q[7] <= glyph(units(m));
		end
	end

endmodule

/* hw/rtl/seven_segment_clock_scan_driver_unit.sv */
// Top level of the eight-digit seven-segment scan driver.
// Depends on sssd_pkg, sssd_core and sssd_result_queue.
//
// Drives an eight-digit multiplexed common-cathode display. A time request
// (opcode 0) stores hour and minute and enables scanning; a remote request
// (opcode 1) stores a digit 0..9, larger values are dropped. Either one
// rebuilds the display buffer (three blanks, remote digit, HH.M.M) only when
// hour <= 23 and minute <= 59, otherwise the old buffer is kept. Each scan
// tick (opcode 2), once a time has arrived, gives two responses: a blank on
// the previously driven select (last = 0), then the next digit's segments on
// its select (last = 1), both tagged with the scan count before this tick.
// Requests enter an input register and are executed from it one per cycle;
// time and remote requests give no response. A scan request passes the
// input register, then its response pair is written into a two-entry
// result queue, from which the blank response leaves first and the digit
// response after it. A scan held in the input register waits for
// the cycle the queue's last entry leaves and holds off new requests until
// then; any other request passes while a pair waits. Opcode 3 is ignored.
// No clearing pass after reset.
module seven_segment_clock_scan_driver_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  sssd_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output sssd_pkg::rsp_t rsp
);
	import sssd_pkg::*;

	// input register
	logic      valid_s1;
	req_t      req_s1;
	logic      take;
	q_push_t   push;
	q_status_t status;

	assign req_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// state update and response generation
	sssd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1),
		.status   (status),
		.take     (take),
		.push     (push)
	);

	// output side: blank/digit pair
	sssd_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// a blank response is always followed directly by its digit response
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp.last |=> rsp_valid && rsp.last)
		else $error("digit response missing after blank");

	// both responses of one scan carry the same count
	a_pair_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp.last |=> rsp.scan_total == $past(rsp.scan_total))
		else $error("scan count differs within a pair");

	// a new pair is only written when the queue drains this cycle
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> !rsp_valid || (rsp_ready && rsp.last))
		else $error("result queue overrun");

endmodule
